### src/rst_controller_saturated_assert.svh
// ----------------------------------------------------------------------------
// RST controller assertion macros
// Shared property wrappers, clocked by i_clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef RST_CONTROLLER_SATURATED_ASSERT_SVH
`define RST_CONTROLLER_SATURATED_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RSTC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RSTC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/rstc_pkg.sv
// ----------------------------------------------------------------------------
// rstc_pkg
// Types and fixed-point constants shared by the RST controller modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rstc_pkg;

    localparam int COEF_W    = 32;  // Q2.29
    localparam int SMP_W     = 24;  // Q7.16
    localparam int CMD_W     = 17;  // unsigned Q1.16
    localparam int MUL_B_W   = SMP_W + 1;
    localparam int PROD_W    = COEF_W + MUL_B_W;
    localparam int ACC_W     = 62;
    localparam int FRAC_DROP = 29;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [CMD_W-1:0] CMD_ONE      = 17'd65536;
    localparam logic [CMD_W-1:0] SAT_HIGH_RST = 17'd52429;
    localparam logic [CMD_W-1:0] SAT_LOW_RST  = 17'd13107;

    localparam logic signed [ACC_W-1:0] RND_HALF =
        {{(ACC_W-FRAC_DROP){1'b0}}, 1'b1, {(FRAC_DROP-1){1'b0}}};

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    localparam logic REG_SAT_HIGH = 1'b0;
    localparam logic REG_SAT_LOW  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_ROUND,
        ST_CLAMP,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic start;
        logic load;
        logic issue;
        logic round;
        logic clamp;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic last_tap;
        logic pipe_busy;
    } t_dp_sts;

endpackage

`default_nettype wire

### src/rstc_ram.sv
// ----------------------------------------------------------------------------
// rstc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rstc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 14
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### src/rstc_ctrl.sv
// ----------------------------------------------------------------------------
// rstc_ctrl
// Sequencer: takes items, steps the MAC over all taps, rounds, clamps, emits.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rst_controller_saturated_assert.svh"

module rstc_ctrl
    import rstc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_in_kind,
    input  wire logic    i_out_free,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd,
    output logic         o_in_stall
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_in_kind == KIND_SAMPLE) begin
                    n_state = ST_MAC;
                end
            end
            ST_MAC: begin
                if (i_sts.last_tap) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                n_state = ST_CLAMP;
            end
            ST_CLAMP: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall  = 1'b0;
                o_cmd.start = i_in_valid && (i_in_kind == KIND_SAMPLE);
                o_cmd.load  = i_in_valid && (i_in_kind == KIND_LOAD);
            end
            ST_MAC: begin
                o_cmd.issue = 1'b1;
            end
            ST_DRAIN: begin
                o_cmd.issue = 1'b0;
            end
            ST_ROUND: begin
                o_cmd.round = 1'b1;
            end
            ST_CLAMP: begin
                o_cmd.clamp = 1'b1;
            end
            ST_EMIT: begin
                o_cmd.emit = i_out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // The multiply pipeline may only hold work while taps are being issued or drained.
    `RSTC_ASSERT_NOW(a_busy_in_mac, i_sts.pipe_busy, (r_state == ST_MAC) || (r_state == ST_DRAIN), "MAC pipeline busy outside the MAC phase")
    `RSTC_ASSERT_NOW(a_round_empty, r_state == ST_ROUND, !i_sts.pipe_busy, "rounding started before the accumulator settled")
    `RSTC_ASSERT_NEXT(a_emit_hold, (r_state == ST_EMIT) && !i_out_free, r_state == ST_EMIT, "result dropped while the output was stalled")

endmodule

`default_nettype wire

### src/rstc_dpath.sv
// ----------------------------------------------------------------------------
// rstc_dpath
// Histories, coefficient store, shared multiply-accumulate, rounding and clamp.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rst_controller_saturated_assert.svh"

module rstc_dpath
    import rstc_pkg::*;
#(
    parameter int SETPOINT_TAPS = 7,
    parameter int MEASURED_TAPS = 3,
    parameter int COMMAND_TAPS  = 4
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_dp_cmd                  i_cmd,
    output t_dp_sts                       o_sts,
    input  wire logic [3:0]               i_coef_index,
    input  wire logic signed [COEF_W-1:0] i_coef_value,
    input  wire logic signed [SMP_W-1:0]  i_setpoint,
    input  wire logic signed [SMP_W-1:0]  i_measured,
    input  wire logic [CMD_W-1:0]         i_sat_high,
    input  wire logic [CMD_W-1:0]         i_sat_low,
    output logic [CMD_W-1:0]              o_command
);

    localparam int TOTAL = COMMAND_TAPS + MEASURED_TAPS + SETPOINT_TAPS;
    localparam int TAP_W = $clog2(TOTAL);
    localparam int SUB_END = COMMAND_TAPS + MEASURED_TAPS;

    logic signed [SMP_W-1:0] r_sp_hist  [SETPOINT_TAPS];
    logic signed [SMP_W-1:0] r_ms_hist  [MEASURED_TAPS];
    logic [CMD_W-1:0]        r_cmd_hist [COMMAND_TAPS];
    logic [TOTAL-1:0]        r_coef_vld;

    logic [TAP_W-1:0]          r_tap;
    logic                      r_v1;
    logic                      r_v2;
    logic                      r_sub1;
    logic                      r_sub2;
    logic                      r_rd_vld;
    logic signed [MUL_B_W-1:0] r_smp;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic [CMD_W-1:0]          r_cmd;

    logic                      coef_we;
    logic [TAP_W-1:0]          coef_waddr;
    logic [COEF_W-1:0]         coef_rdata;
    logic signed [COEF_W-1:0]  coef_eff;
    logic signed [MUL_B_W-1:0] n_smp;
    logic                      last_tap;
    logic signed [ACC_W-1:0]   prod_ext;
    logic signed [ACC_W-1:0]   hi_lim;
    logic signed [ACC_W-1:0]   lo_lim;

    assign coef_waddr = TAP_W'(i_coef_index);
    assign coef_we    = i_cmd.load && (32'(i_coef_index) < 32'(TOTAL));
    assign last_tap   = (r_tap == TAP_W'(TOTAL - 1));

    rstc_ram #(
        .WIDTH (COEF_W),
        .DEPTH (TOTAL)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (coef_waddr),
        .i_wdata (i_coef_value),
        .i_raddr (r_tap),
        .o_rdata (coef_rdata)
    );

    // Taps are ordered like the coefficient slots: commands, measurements, setpoints.
    always_comb begin
        n_smp = '0;
        for (int j = 0; j < COMMAND_TAPS; j++) begin
            if (r_tap == TAP_W'(j)) begin
                n_smp = $signed({{(MUL_B_W-CMD_W){1'b0}}, r_cmd_hist[j]});
            end
        end
        for (int j = 0; j < MEASURED_TAPS; j++) begin
            if (r_tap == TAP_W'(COMMAND_TAPS + j)) begin
                n_smp = MUL_B_W'(r_ms_hist[j]);
            end
        end
        for (int j = 0; j < SETPOINT_TAPS; j++) begin
            if (r_tap == TAP_W'(SUB_END + j)) begin
                n_smp = MUL_B_W'(r_sp_hist[j]);
            end
        end
    end

    // A slot that was never loaded still reads as zero after reset.
    assign coef_eff = r_rd_vld ? $signed(coef_rdata) : '0;
    assign prod_ext = ACC_W'(r_prod);
    assign hi_lim   = $signed({{(ACC_W-CMD_W-FRAC_DROP){1'b0}}, i_sat_high,
                               {FRAC_DROP{1'b0}}});
    assign lo_lim   = $signed({{(ACC_W-CMD_W-FRAC_DROP){1'b0}}, i_sat_low,
                               {FRAC_DROP{1'b0}}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < SETPOINT_TAPS; j++) begin
                r_sp_hist[j] <= '0;
            end
            for (int j = 0; j < MEASURED_TAPS; j++) begin
                r_ms_hist[j] <= '0;
            end
            for (int j = 0; j < COMMAND_TAPS; j++) begin
                r_cmd_hist[j] <= CMD_ONE;
            end
            r_coef_vld <= '0;
            r_tap      <= '0;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
        end else begin
            if (coef_we) begin
                r_coef_vld[coef_waddr] <= 1'b1;
            end
            if (i_cmd.start) begin
                for (int j = SETPOINT_TAPS - 1; j > 0; j--) begin
                    r_sp_hist[j] <= r_sp_hist[j-1];
                end
                r_sp_hist[0] <= i_setpoint;
                for (int j = MEASURED_TAPS - 1; j > 0; j--) begin
                    r_ms_hist[j] <= r_ms_hist[j-1];
                end
                r_ms_hist[0] <= i_measured;
                r_tap <= '0;
            end else if (i_cmd.issue && !last_tap) begin
                r_tap <= r_tap + 1'b1;
            end
            if (i_cmd.emit) begin
                for (int j = COMMAND_TAPS - 1; j > 0; j--) begin
                    r_cmd_hist[j] <= r_cmd_hist[j-1];
                end
                r_cmd_hist[0] <= r_cmd;
            end
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
        end
    end

    // Three-stage MAC: fetch coefficient and sample, multiply, accumulate.
    always_ff @(posedge i_clk) begin
        r_rd_vld <= r_coef_vld[r_tap];
        r_smp    <= n_smp;
        r_sub1   <= (r_tap < TAP_W'(SUB_END));
        r_sub2   <= r_sub1;
        r_prod   <= coef_eff * r_smp;
        if (i_cmd.start) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_sub2 ? (r_acc - prod_ext) : (r_acc + prod_ext);
        end else if (i_cmd.round) begin
            r_acc <= r_acc + RND_HALF;
        end
        if (i_cmd.clamp) begin
            if (r_acc >= hi_lim) begin
                r_cmd <= i_sat_high;
            end else if (r_acc < lo_lim) begin
                r_cmd <= i_sat_low;
            end else begin
                r_cmd <= r_acc[FRAC_DROP +: CMD_W];
            end
        end
    end

    assign o_sts.last_tap  = last_tap;
    assign o_sts.pipe_busy = r_v1 || r_v2;
    assign o_command       = r_cmd;

    `RSTC_ASSERT_NOW(a_tap_bound, 1'b1, r_tap <= TAP_W'(TOTAL - 1), "tap counter ran past the last coefficient")
    `RSTC_ASSERT_NOW(a_cmd_range, i_cmd.emit, (r_cmd == i_sat_high) || (r_cmd == i_sat_low) || ((r_cmd < i_sat_high) && (r_cmd >= i_sat_low)), "emitted command escaped the clamp")
    `RSTC_ASSERT_NEXT(a_hist_push, i_cmd.emit, r_cmd_hist[0] == $past(r_cmd), "emitted command missing from the history")

endmodule

`default_nettype wire

### src/rst_controller_saturated.sv
// ----------------------------------------------------------------------------
// rst_controller_saturated
// Fixed-point RST regulator with a clamped drive command and an APB register
// port for the clamp limits.
//
//   Channel  Direction  Handshake           Payload
//   input    in         i_valid / o_stall   i_kind, i_coef_index, i_coef_value,
//                                           i_setpoint, i_measured
//   output   out        o_valid / i_stall   o_command
//   config   in         APB write/read      sat_high (0x0), sat_low (0x4)
//
// A load word is written without leaving idle. A sample word is worked
// through one shared multiply-accumulate unit, one tap per cycle over all
// TOTAL taps (TOTAL = COMMAND_TAPS + MEASURED_TAPS + SETPOINT_TAPS, 14 by
// default), and no further word is taken until its command is emitted.
// Reset takes effect at once; no clearing pass follows it.
// The finished command sits in an output register, so new words are taken
// while it waits; a stall only holds the block once a second command is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module rst_controller_saturated
    import rstc_pkg::*;
#(
    parameter int SETPOINT_TAPS = 7,
    parameter int MEASURED_TAPS = 3,
    parameter int COMMAND_TAPS  = 4
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,

    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic                     i_kind,
    input  wire logic [3:0]               i_coef_index,
    input  wire logic signed [COEF_W-1:0] i_coef_value,
    input  wire logic signed [SMP_W-1:0]  i_setpoint,
    input  wire logic signed [SMP_W-1:0]  i_measured,

    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic [CMD_W-1:0]              o_command,

    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_AW-1:0]        paddr,
    input  wire logic [APB_DW-1:0]        pwdata,
    output logic [APB_DW-1:0]             prdata,
    output logic                          pready
);

    logic [CMD_W-1:0] r_sat_high;
    logic [CMD_W-1:0] r_sat_low;
    logic             r_out_vld;
    logic [CMD_W-1:0] r_out_cmd;

    t_dp_cmd          dp_cmd;
    t_dp_sts          dp_sts;
    logic             out_free;
    logic             in_stall;
    logic             reg_wr;
    logic [CMD_W-1:0] dp_command;

    assign pready   = 1'b1;
    assign reg_wr   = psel && penable && pwrite && pready;
    assign out_free = !r_out_vld || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat_high <= SAT_HIGH_RST;
            r_sat_low  <= SAT_LOW_RST;
        end else if (reg_wr) begin
            case (paddr[2])
                REG_SAT_HIGH: r_sat_high <= pwdata[CMD_W-1:0];
                REG_SAT_LOW:  r_sat_low  <= pwdata[CMD_W-1:0];
                default:      r_sat_high <= r_sat_high;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_SAT_HIGH: prdata = APB_DW'(r_sat_high);
            REG_SAT_LOW:  prdata = APB_DW'(r_sat_low);
            default:      prdata = '0;
        endcase
    end

    rstc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_in_kind  (i_kind),
        .i_out_free (out_free),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd),
        .o_in_stall (in_stall)
    );

    rstc_dpath #(
        .SETPOINT_TAPS (SETPOINT_TAPS),
        .MEASURED_TAPS (MEASURED_TAPS),
        .COMMAND_TAPS  (COMMAND_TAPS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_sts        (dp_sts),
        .i_coef_index (i_coef_index),
        .i_coef_value (i_coef_value),
        .i_setpoint   (i_setpoint),
        .i_measured   (i_measured),
        .i_sat_high   (r_sat_high),
        .i_sat_low    (r_sat_low),
        .o_command    (dp_command)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (dp_cmd.emit) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (dp_cmd.emit) begin
            r_out_cmd <= dp_command;
        end
    end

    assign o_stall   = in_stall;
    assign o_valid   = r_out_vld;
    assign o_command = r_out_cmd;

endmodule

`default_nettype wire

### dv/rstc_command_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rstc_command_checker
// Watches the word channels and the register port of the RST controller,
// predicts every drive command on its own and compares it with the output.
// ----------------------------------------------------------------------------

module rstc_command_checker
    import rstc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic                     kind,
    input  logic [3:0]               coef_index,
    input  logic signed [COEF_W-1:0] coef_value,
    input  logic signed [SMP_W-1:0]  setpoint,
    input  logic signed [SMP_W-1:0]  measured,

    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic [CMD_W-1:0]         command,

    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic                     pready,
    input  logic [APB_AW-1:0]        paddr,
    input  logic [APB_DW-1:0]        pwdata,

    output int                       fail_count,
    output int                       pending_count
);

    localparam int CMD_TAPS   = 4;
    localparam int MEAS_TAPS  = 3;
    localparam int SP_TAPS    = 7;
    localparam int COEF_SLOTS = CMD_TAPS + MEAS_TAPS + SP_TAPS;
    localparam int SHOWN_FAILS = 10;

    localparam logic [APB_AW-1:0] ADDR_SAT_HIGH = {REG_SAT_HIGH, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_SAT_LOW  = {REG_SAT_LOW, 2'b00};

    longint           coefs    [COEF_SLOTS];
    longint           sp_hist  [SP_TAPS];
    longint           ms_hist  [MEAS_TAPS];
    logic [CMD_W-1:0] cmd_hist [CMD_TAPS];
    logic [CMD_W-1:0] sat_high_q;
    logic [CMD_W-1:0] sat_low_q;
    logic [CMD_W-1:0] expected_commands [$];
    logic [CMD_W-1:0] oldest;
    int               fails = 0;

    function automatic void note_failure(input string what);
        fails++;
        if (fails <= SHOWN_FAILS) begin
            $display("%0t ns: %s", $time, what);
        end
    endfunction

    // Shifts the new samples in, runs the filter sum, rounds and clamps the result.
    // The command is also shifted into its own history here.
    function automatic logic [CMD_W-1:0] predict_command(input longint sp, input longint ms);
        longint           acc;
        longint           rounded;
        logic [CMD_W-1:0] cmd;
        for (int k = SP_TAPS - 1; k > 0; k--) begin
            sp_hist[k] = sp_hist[k-1];
        end
        sp_hist[0] = sp;
        for (int k = MEAS_TAPS - 1; k > 0; k--) begin
            ms_hist[k] = ms_hist[k-1];
        end
        ms_hist[0] = ms;

        acc = 0;
        for (int k = 0; k < CMD_TAPS; k++) begin
            acc -= coefs[k] * longint'(cmd_hist[k]);
        end
        for (int k = 0; k < MEAS_TAPS; k++) begin
            acc -= coefs[CMD_TAPS + k] * ms_hist[k];
        end
        for (int k = 0; k < SP_TAPS; k++) begin
            acc += coefs[CMD_TAPS + MEAS_TAPS + k] * sp_hist[k];
        end

        // Round half up, then test the upper limit first so that crossed
        // limits resolve the same way as in the design.
        rounded = acc + (64'sd1 <<< (FRAC_DROP - 1));
        if (rounded >= (longint'(sat_high_q) <<< FRAC_DROP)) begin
            cmd = sat_high_q;
        end else if (rounded < (longint'(sat_low_q) <<< FRAC_DROP)) begin
            cmd = sat_low_q;
        end else begin
            cmd = CMD_W'(rounded >>> FRAC_DROP);
        end

        for (int k = CMD_TAPS - 1; k > 0; k--) begin
            cmd_hist[k] = cmd_hist[k-1];
        end
        cmd_hist[0] = cmd;
        return cmd;
    endfunction

    always @(posedge clk) begin
        if (!rst_n) begin
            sat_high_q = SAT_HIGH_RST;
            sat_low_q  = SAT_LOW_RST;
            foreach (coefs[k]) coefs[k] = 0;
            foreach (sp_hist[k]) sp_hist[k] = 0;
            foreach (ms_hist[k]) ms_hist[k] = 0;
            foreach (cmd_hist[k]) cmd_hist[k] = CMD_ONE;
            expected_commands.delete();
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_commands.size() == 0) begin
                    note_failure($sformatf("command %0d arrived with none expected", command));
                end else begin
                    oldest = expected_commands.pop_front();
                    if (command !== oldest) begin
                        note_failure($sformatf("command mismatch: expected %0d, got %0d",
                                               oldest, command));
                    end
                end
            end

            if (in_valid && !in_stall) begin
                if (kind == KIND_SAMPLE) begin
                    expected_commands.push_back(predict_command(setpoint, measured));
                end else if (coef_index < COEF_SLOTS) begin
                    coefs[coef_index] = longint'(coef_value);
                end
            end

            if (psel && penable && pwrite && pready) begin
                if (paddr == ADDR_SAT_HIGH) begin
                    sat_high_q = pwdata[CMD_W-1:0];
                end else if (paddr == ADDR_SAT_LOW) begin
                    sat_low_q = pwdata[CMD_W-1:0];
                end
            end
        end
        fail_count    <= fails;
        pending_count <= expected_commands.size();
    end

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives coefficient loads and control samples into the RST controller under
// several clamp settings and handshake pressures; a checker beside the block
// predicts and compares every command.
// ----------------------------------------------------------------------------

module testbench;
    import rstc_pkg::*;

    localparam int PHASES          = 6;
    localparam int WORDS_PER_PHASE = 210;
    localparam int SETTLE_CYCLES   = 30;

    localparam logic [APB_AW-1:0] ADDR_SAT_HIGH = {REG_SAT_HIGH, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_SAT_LOW  = {REG_SAT_LOW, 2'b00};

    localparam logic signed [COEF_W-1:0] COEF_ONE  = 32'sh2000_0000;
    localparam logic signed [COEF_W-1:0] COEF_HALF = 32'sh1000_0000;
    localparam logic signed [COEF_W-1:0] COEF_MAX  = 32'sh7fff_ffff;
    localparam logic signed [COEF_W-1:0] COEF_MIN  = 32'sh8000_0000;
    localparam logic signed [SMP_W-1:0]  VOLT_MAX  = 24'sh7f_ffff;
    localparam logic signed [SMP_W-1:0]  VOLT_MIN  = 24'sh80_0000;

    logic                     i_clk        = 1'b0;
    logic                     i_rst_n      = 1'b0;
    logic                     i_valid      = 1'b0;
    logic                     o_stall;
    logic                     i_kind       = KIND_LOAD;
    logic [3:0]               i_coef_index = '0;
    logic signed [COEF_W-1:0] i_coef_value = '0;
    logic signed [SMP_W-1:0]  i_setpoint   = '0;
    logic signed [SMP_W-1:0]  i_measured   = '0;
    logic                     o_valid;
    logic                     i_stall      = 1'b0;
    logic [CMD_W-1:0]         o_command;
    logic                     psel         = 1'b0;
    logic                     penable      = 1'b0;
    logic                     pwrite       = 1'b0;
    logic [APB_AW-1:0]        paddr        = '0;
    logic [APB_DW-1:0]        pwdata       = '0;
    logic [APB_DW-1:0]        prdata;
    logic                     pready;

    int fail_count;
    int pending_count;
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;

    always #4 i_clk = ~i_clk;

    rst_controller_saturated i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_kind       (i_kind),
        .i_coef_index (i_coef_index),
        .i_coef_value (i_coef_value),
        .i_setpoint   (i_setpoint),
        .i_measured   (i_measured),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_command    (o_command),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    rstc_command_checker u_checker (
        .clk           (i_clk),
        .rst_n         (i_rst_n),
        .in_valid      (i_valid),
        .in_stall      (o_stall),
        .kind          (i_kind),
        .coef_index    (i_coef_index),
        .coef_value    (i_coef_value),
        .setpoint      (i_setpoint),
        .measured      (i_measured),
        .out_valid     (o_valid),
        .out_stall     (i_stall),
        .command       (o_command),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Half of the draws are moderate values so that the command often lands between
    // the limits; a quarter are zero and a quarter use the full range.
    function automatic logic signed [COEF_W-1:0] rand_coef();
        case ($urandom_range(0, 3))
            0:       return $urandom();
            1:       return '0;
            default: return $urandom_range(0, 1 << 29) - (1 << 28);
        endcase
    endfunction

    function automatic logic signed [SMP_W-1:0] rand_volt();
        if ($urandom_range(0, 3) == 0) begin
            return SMP_W'($urandom());
        end
        return SMP_W'($urandom_range(0, 1 << 18) - (1 << 17));
    endfunction

    task automatic send_word(input logic kind, input logic [3:0] idx,
                             input logic signed [COEF_W-1:0] value,
                             input logic signed [SMP_W-1:0] sp,
                             input logic signed [SMP_W-1:0] ms);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_kind       <= kind;
        i_coef_index <= idx;
        i_coef_value <= value;
        i_setpoint   <= sp;
        i_measured   <= ms;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic send_load(input logic [3:0] idx, input logic signed [COEF_W-1:0] value);
        send_word(KIND_LOAD, idx, value, rand_volt(), rand_volt());
    endtask

    task automatic send_sample(input logic signed [SMP_W-1:0] sp,
                               input logic signed [SMP_W-1:0] ms);
        send_word(KIND_SAMPLE, 4'($urandom()), $urandom(), sp, ms);
    endtask

    task automatic drain_commands();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
    endtask

    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        logic [CMD_W-1:0] hi;
        logic [CMD_W-1:0] lo;
        logic [3:0]       idx;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // With all coefficients zero the sum is zero and ends below the low limit.
        send_sample(0, 0);
        // Loads to slots that do not exist must leave every coefficient alone.
        send_load(4'd14, COEF_MAX);
        send_load(4'd15, COEF_MIN);
        send_sample(VOLT_MAX, VOLT_MIN);
        // A negative coefficient on the latest past command drives the sum high.
        send_load(4'd0, COEF_MIN);
        send_sample(0, 0);
        send_load(4'd0, 0);
        send_load(4'd7, COEF_ONE);
        send_sample(24'sd32768, 0);
        send_load(4'd4, COEF_ONE);
        send_sample(24'sd32768, 24'sd8192);
        // An exact half LSB must round up; then hit both limits exactly.
        send_load(4'd4, 0);
        send_load(4'd7, COEF_HALF);
        send_sample(24'sd32769, 0);
        send_sample(24'sd104858, 0);
        send_sample(24'sd26214, 0);
        send_load(4'd13, COEF_MAX);
        send_load(4'd3, COEF_MAX);
        send_load(4'd6, COEF_MIN);
        send_sample(VOLT_MAX, VOLT_MAX);
        send_sample(VOLT_MIN, VOLT_MIN);
        send_sample(VOLT_MIN, VOLT_MAX);

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase != 0) begin
                drain_commands();
                repeat (SETTLE_CYCLES) @(posedge i_clk);
                case (phase)
                    1:       begin hi = 17'd65536;  lo = 17'd0;     end
                    2:       begin hi = 17'd0;      lo = 17'd65536; end
                    3:       begin hi = 17'd131071; lo = 17'd0;     end
                    4:       begin hi = 17'd40000;  lo = 17'd50000; end
                    default: begin
                        hi = CMD_W'($urandom_range(0, 65536));
                        lo = CMD_W'($urandom_range(0, 131071));
                    end
                endcase
                apb_write(ADDR_SAT_HIGH, APB_DW'(hi));
                apb_write(ADDR_SAT_LOW, APB_DW'(lo));
            end
            case (phase % 4)
                0:       begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin sender_idle_pct = 73; recv_stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  recv_stall_pct = 73; end
                default: begin sender_idle_pct = 16; recv_stall_pct = 16; end
            endcase

            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                if ($urandom_range(0, 99) < 30) begin
                    idx = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(14, 15))
                                                       : 4'($urandom_range(0, 13));
                    send_load(idx, rand_coef());
                end else begin
                    send_sample(rand_volt(), rand_volt());
                end
                // Now and then hold off new words until every command is out.
                if ($urandom_range(0, 149) == 0) begin
                    drain_commands();
                end
            end
        end

        drain_commands();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("rst_controller_saturated test passed");
        end else begin
            $display("rst_controller_saturated test failed");
        end
        $finish;
    end

    initial begin
        #(5_000_000);
        $display("rst_controller_saturated test failed");
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/rstc_pkg.sv
src/rstc_ram.sv
src/rstc_ctrl.sv
src/rstc_dpath.sv
src/rst_controller_saturated.sv
dv/rstc_command_checker.sv
dv/testbench.sv
